@@ rtl/u8sd_pkg.sv @@
// Shared types, constants and helpers of the UTF-8 stream decoder.
package u8sd_pkg;

  // Longest sequence accepted, in bytes (4 to 6).
  localparam int MAX_SEQ_BYTES = 6;

  // Token queue between the classifier and the sequencer.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Widths of the decoder state and the result fields.
  localparam int ACC_W  = 31;
  localparam int CP_W   = 21;
  localparam int KIND_W = 2;
  localparam int REM_W  = 3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_VALID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOF   = 2'd2;

  // Code point limits.
  localparam logic [ACC_W-1:0] CP_MAX     = 31'h0010_FFFF;
  localparam logic [CP_W-1:0]  CP_ERR     = 21'h00_FFFD;
  localparam logic [ACC_W-1:0] SURR_LO    = 31'h0000_D800;
  localparam logic [ACC_W-1:0] SURR_HI    = 31'h0000_DFFF;
  localparam logic [ACC_W-1:0] NONCHAR_LO = 31'h0000_FDD0;
  localparam logic [ACC_W-1:0] NONCHAR_HI = 31'h0000_FDEF;
  localparam logic [15:0]      NONCHAR_FE = 16'hFFFE;

  // Byte class that the front end assigns to each input transaction.
  typedef enum logic [2:0] {
    CLS_EOF   = 3'd0,
    CLS_CONT  = 3'd1,
    CLS_LEAD1 = 3'd2,
    CLS_LEADN = 3'd3,
    CLS_BAD   = 3'd4
  } cls_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    cls_t              cls;
    logic [REM_W-1:0]  rem;      // continuation bytes that a multibyte lead opens
    logic [7:0]        payload;  // masked payload bits of the byte
  } token_t;

  // Sequence length of a lead byte: 1 to 6, or 0 for an invalid lead.
  function automatic logic [REM_W-1:0] lead_length(input logic [7:0] b);
    logic [REM_W-1:0] len;
    len = '0;
    casez (b)
      8'b0???????: len = 3'd1;
      8'b10??????: len = 3'd0;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      8'b111110??: len = 3'd5;
      8'b1111110?: len = 3'd6;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  // Payload mask of a lead byte of the given length.
  function automatic logic [7:0] lead_mask(input logic [REM_W-1:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      default: m = 8'h01;
    endcase
    return m;
  endfunction

  // Check a finished multibyte value for range, surrogates and noncharacters.
  function automatic logic value_ok(input logic [ACC_W-1:0] v);
    return (v <= CP_MAX)
        && ((v[15:0] & NONCHAR_FE) != NONCHAR_FE)
        && ((v < SURR_LO) || (v > SURR_HI))
        && ((v < NONCHAR_LO) || (v > NONCHAR_HI));
  endfunction

endpackage

@@ rtl/u8sd_if.sv @@
// Handshake interfaces of the byte input channel and the result channel.
interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface u8sd_out_if;
  logic                        valid;
  logic                        ready;
  logic [u8sd_pkg::CP_W-1:0]   code_point;
  logic [u8sd_pkg::KIND_W-1:0] kind;

  modport source (output valid, output code_point, output kind, input ready);
  modport sink   (input valid, input code_point, input kind, output ready);
endinterface

@@ rtl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder: classifier, token queue, sequencer.
//
//   channel  dir  payload                          transaction
//   in_ch    in   data_byte[7:0], end_of_file      valid && ready
//   out_ch   out  code_point[20:0], kind[1:0]      valid && ready
//
// One byte per cycle sustained while out_ch is ready; a byte passes the classifier
// stage and the queue before the sequencer registers its result.
// The sequencer step (six-bit shift and code point check) sets the rate.
// Synchronous active-low reset clears the sequence state and empties the queue.
// A stall on out_ch backs up through the queue to in_ch; each side stalls on its own.
module utf8_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  u8sd_in_if.sink    in_ch,
  u8sd_out_if.source out_ch
);

  logic             f_valid, f_ready;
  u8sd_pkg::token_t f_tok;
  logic             b_valid, b_ready;
  u8sd_pkg::token_t b_tok;

  u8sd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  u8sd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_tok    (b_tok)
  );

  u8sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (b_valid),
    .tok_ready (b_ready),
    .tok       (b_tok),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/u8sd_front.sv @@
// Front end: accept input bytes, classify them and register one token.
module u8sd_front (
  input  logic             clk,
  input  logic             rst_n,
  u8sd_in_if.sink          in_ch,
  output logic             tok_valid,
  input  logic             tok_ready,
  output u8sd_pkg::token_t tok
);

  logic             tok_v_r;
  logic             tok_v_nxt;
  u8sd_pkg::token_t tok_r;
  u8sd_pkg::token_t tok_nxt;
  logic [u8sd_pkg::REM_W-1:0] len;
  logic             take;

  // Accept while the stage is empty or drains this cycle.
  assign in_ch.ready = !tok_v_r || tok_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Classify the byte of the incoming transaction.
  always_comb begin
    len     = u8sd_pkg::lead_length(in_ch.data_byte);
    tok_nxt = '{cls: u8sd_pkg::CLS_BAD, rem: '0, payload: in_ch.data_byte};
    if (in_ch.end_of_file) begin
      tok_nxt.cls     = u8sd_pkg::CLS_EOF;
      tok_nxt.payload = '0;
    end else if (in_ch.data_byte[7:6] == 2'b10) begin
      tok_nxt.cls     = u8sd_pkg::CLS_CONT;
      tok_nxt.payload = {2'b00, in_ch.data_byte[5:0]};
    end else if (len == 3'd1) begin
      tok_nxt.cls = u8sd_pkg::CLS_LEAD1;
    end else if ((len != 3'd0) && (len <= u8sd_pkg::REM_W'(u8sd_pkg::MAX_SEQ_BYTES))) begin
      tok_nxt.cls     = u8sd_pkg::CLS_LEADN;
      tok_nxt.rem     = len - 3'd1;
      tok_nxt.payload = in_ch.data_byte & u8sd_pkg::lead_mask(len);
    end
  end

  // Hold the token until the queue takes it.
  always_comb begin
    tok_v_nxt = tok_v_r;
    if (take) begin
      tok_v_nxt = 1'b1;
    end else if (tok_ready) begin
      tok_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid = tok_v_r;
  assign tok       = tok_r;

endmodule

@@ rtl/u8sd_fifo.sv @@
// Short token queue between the classifier and the sequencer.
module u8sd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  u8sd_pkg::token_t push_tok,
  output logic             pop_valid,
  input  logic             pop_ready,
  output u8sd_pkg::token_t pop_tok
);

  u8sd_pkg::token_t mem [u8sd_pkg::FIFO_DEPTH];
  logic [u8sd_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u8sd_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u8sd_pkg::FIFO_AW:0]   cnt_r, cnt_nxt;
  logic                         push, pop;

  assign push_ready = (cnt_r != (u8sd_pkg::FIFO_AW+1)'(u8sd_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = mem[rd_ptr_r];

  // Advance pointers and occupancy.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed token.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

endmodule

@@ rtl/u8sd_back.sv @@
// Back end: run the sequence state over tokens and register the results.
module u8sd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  output logic             tok_ready,
  input  u8sd_pkg::token_t tok,
  u8sd_out_if.source       out_ch
);

  logic [u8sd_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [u8sd_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic                        out_v_r, out_v_nxt;
  logic [u8sd_pkg::CP_W-1:0]   cp_r, cp_nxt;
  logic [u8sd_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [u8sd_pkg::ACC_W-1:0]  shifted;
  logic                        emit;
  logic                        pop;

  // Take a token when the output register is free or drains this cycle.
  assign tok_ready = !out_v_r || out_ch.ready;
  assign pop       = tok_valid && tok_ready;
  assign shifted   = {acc_r[u8sd_pkg::ACC_W-7:0], tok.payload[5:0]};

  // Step the sequence state for one token.
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    emit     = 1'b0;
    cp_nxt   = u8sd_pkg::CP_ERR;
    kind_nxt = u8sd_pkg::KIND_ERROR;
    if (rem_r == '0) begin
      case (tok.cls)
        u8sd_pkg::CLS_EOF: begin
          emit     = 1'b1;
          cp_nxt   = '0;
          kind_nxt = u8sd_pkg::KIND_EOF;
        end
        u8sd_pkg::CLS_LEAD1: begin
          emit     = 1'b1;
          cp_nxt   = u8sd_pkg::CP_W'(tok.payload);
          kind_nxt = u8sd_pkg::KIND_VALID;
        end
        u8sd_pkg::CLS_LEADN: begin
          acc_nxt = u8sd_pkg::ACC_W'(tok.payload);
          rem_nxt = tok.rem;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end else if (tok.cls == u8sd_pkg::CLS_CONT) begin
      acc_nxt = shifted;
      rem_nxt = rem_r - 1'b1;
      if (rem_r == 3'd1) begin
        emit = 1'b1;
        if (u8sd_pkg::value_ok(shifted)) begin
          cp_nxt   = shifted[u8sd_pkg::CP_W-1:0];
          kind_nxt = u8sd_pkg::KIND_VALID;
        end
      end
    end else begin
      // Drop the sequence on a missing continuation or an early end of file.
      emit = 1'b1;
    end
    if (emit) begin
      acc_nxt = '0;
      rem_nxt = '0;
    end
  end

  // Hold a result until the sink takes it.
  always_comb begin
    out_v_nxt = out_v_r;
    if (pop && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      rem_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (pop) begin
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      cp_r   <= cp_nxt;
      kind_r <= kind_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.code_point = cp_r;
  assign out_ch.kind       = kind_r;

endmodule
